>>> rtl/core/isr_pkg.sv
package isr_pkg;

  localparam int INPUT_BITS = 32;
  localparam int ITERS      = (INPUT_BITS + 1) / 2;
  localparam int RAD_BITS   = 2 * ITERS;
  localparam int REM_BITS   = ITERS + 3;
  localparam int ROOT_BITS  = INPUT_BITS / 2 + 1;
  localparam int CNT_BITS   = $clog2(ITERS + 1);

  typedef struct packed {
    logic load;
    logic step;
  } isr_ctl_t;

endpackage

>>> rtl/core/isr_unit.sv
module isr_unit
  import isr_pkg::*;
(
  input  logic                         clk,
  input  isr_ctl_t                     ctl,
  input  logic signed [INPUT_BITS-1:0] value,
  output logic signed [ROOT_BITS-1:0]  root
);

  logic [RAD_BITS-1:0] rad_r, rad_nxt;
  logic [REM_BITS-1:0] rem_r, rem_nxt;
  logic [ITERS-1:0]    q_r, q_nxt;
  logic                neg_r, neg_nxt;

  logic [REM_BITS-1:0] rem_sh;
  logic [REM_BITS-1:0] trial;
  logic                ge;
  logic                up;
  logic [ITERS:0]      rounded;

  assign rem_sh = {rem_r[REM_BITS-3:0], rad_r[RAD_BITS-1 -: 2]};
  assign trial  = REM_BITS'({q_r, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_comb begin
    rad_nxt = rad_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    neg_nxt = neg_r;
    if (ctl.load) begin
      rad_nxt = RAD_BITS'($unsigned(value));
      rem_nxt = '0;
      q_nxt   = '0;
      neg_nxt = value[INPUT_BITS-1];
    end else if (ctl.step) begin
      rad_nxt = rad_r << 2;
      rem_nxt = ge ? (rem_sh - trial) : rem_sh;
      q_nxt   = {q_r[ITERS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
  end

  // round up when the remainder exceeds the floor root
  assign up      = (rem_r > REM_BITS'(q_r));
  assign rounded = {1'b0, q_r} + (ITERS+1)'(up);
  assign root    = neg_r ? {ROOT_BITS{1'b1}} : ROOT_BITS'(rounded);

endmodule

>>> rtl/core/integer_sqrt_rounded_core.sv
// Rounded integer square root.
// Input channel: in_valid / in_stall carry in_value, a signed 32-bit integer.
// Result channel: out_valid / out_stall carry out_root, a signed 17-bit value,
// the square root rounded to nearest, or -1 when in_value is negative.
// A transaction completes at a rising edge with valid high and stall low.
// One bit-pair of the radicand enters the root unit per cycle, so a
// transaction takes 16 iterations (ITERS in general) and then a rounding
// step; a new input is taken only after the rounding step has passed the
// result to the output register.
// in_stall is high while an item is being worked on.
// The finished result sits in an output register; the next input can be taken
// while it waits. If a second result is ready while the receiver still stalls,
// the rounding step holds until the output register frees up.
// rst_n is synchronous and active low: it drops any item in flight and clears
// out_valid. A stalled result holds its value.
module integer_sqrt_rounded_core
  import isr_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [INPUT_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ROOT_BITS-1:0]  out_root
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    ROUND
  } state_t;

  state_t                     state_r;
  logic [CNT_BITS-1:0]        cnt_r;
  logic                       out_valid_r;
  logic signed [ROOT_BITS-1:0] out_root_r;

  isr_ctl_t                   ctl;
  logic signed [ROOT_BITS-1:0] root;
  logic                       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    ctl.load = (state_r == IDLE) && in_valid;
    ctl.step = (state_r == RUN);
  end

  isr_unit u_unit (
    .clk   (clk),
    .ctl   (ctl),
    .value (in_value),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ROUND)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_valid) begin
            cnt_r   <= '0;
            state_r <= RUN;
          end
        end
        RUN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_BITS'(ITERS - 1)) begin
            state_r <= ROUND;
          end
        end
        ROUND: begin
          if (out_free) begin
            out_root_r  <= root;
            out_valid_r <= 1'b1;
            state_r     <= IDLE;
          end else begin
            out_valid_r <= out_valid_r;
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != IDLE);
  assign out_valid = out_valid_r;
  assign out_root  = out_root_r;

endmodule

>>> verif/tb_integer_sqrt_rounded_core.sv
`timescale 1ns / 1ps

module tb_integer_sqrt_rounded_core;
  import isr_pkg::*;

  localparam int RANDOM_ITEMS   = 1750;
  localparam int QUIET_ITEMS    = 150;
  localparam int SEGMENT_ITEMS  = 125;
  localparam int STALL_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_LIMIT   = 10;
  localparam logic signed [ROOT_BITS-1:0] NEG_MARK = '1;

  typedef struct {
    logic signed [INPUT_BITS-1:0] value;
    bit                           typed;
    logic signed [ROOT_BITS-1:0]  root;
  } stim_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [INPUT_BITS-1:0] in_value;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [ROOT_BITS-1:0]  out_root;

  logic signed [ROOT_BITS-1:0] pending_roots[$];
  int  failures     = 0;
  int  idle_cycles  = 0;
  int  stall_left   = 0;
  int  idle_pct     = 0;
  bit  quiet        = 1'b0;

  stim_row_t directed_rows [22] = '{
    '{32'sd0,          1'b1, 17'sd0},
    '{32'sd1,          1'b1, 17'sd1},
    '{32'sd2,          1'b0, 17'sd0},
    '{32'sd3,          1'b0, 17'sd0},
    '{32'sd4,          1'b1, 17'sd2},
    '{32'sd8,          1'b0, 17'sd0},
    '{32'sd9,          1'b1, 17'sd3},
    '{32'sd12,         1'b0, 17'sd0},
    '{32'sd13,         1'b0, 17'sd0},
    '{-32'sd1,         1'b1, NEG_MARK},
    '{32'sh80000000,   1'b1, NEG_MARK},
    '{32'sh7FFFFFFF,   1'b1, 17'sd46341},
    '{32'sd2147395600, 1'b1, 17'sd46340},
    '{32'sd2147441940, 1'b0, 17'sd0},
    '{32'sd2147441941, 1'b0, 17'sd0},
    '{32'sd2147395599, 1'b0, 17'sd0},
    '{32'sh55555555,   1'b0, 17'sd0},
    '{32'shAAAAAAAA,   1'b1, NEG_MARK},
    '{32'sh40000000,   1'b1, 17'sd32768},
    '{32'sh3FFFFFFF,   1'b0, 17'sd0},
    '{32'sd65535,      1'b0, 17'sd0},
    '{32'sd65536,      1'b1, 17'sd256}
  };

  integer_sqrt_rounded_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_root  (out_root)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [ROOT_BITS-1:0] nearest_root(
    input logic signed [INPUT_BITS-1:0] v
  );
    logic [63:0] rest;
    logic [63:0] acc;
    logic [63:0] probe;
    if (v < 0) return NEG_MARK;
    rest  = 64'(unsigned'(v));
    acc   = '0;
    probe = 64'd1 << 62;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= acc + probe) begin
        rest = rest - (acc + probe);
        acc  = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe = probe >> 2;
    end
    if (rest > acc) acc = acc + 1;
    return acc[ROOT_BITS-1:0];
  endfunction

  function automatic logic signed [INPUT_BITS-1:0] random_value();
    logic [63:0] base;
    int unsigned k;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3:       return $urandom_range(0, 300);
      4, 5, 6: begin
        k = $urandom_range(0, 46341);
        base = 64'(k) * 64'(k);
        case ($urandom_range(0, 5))
          0: base = base;
          1: base = base + k;
          2: base = base + k + 1;
          3: base = base + 2 * k;
          4: base = base - 1;
          default: base = base + $urandom_range(0, 2 * k);
        endcase
        if (base > 64'h7FFF_FFFF) base = 64'h7FFF_FFFF;
        return base[INPUT_BITS-1:0];
      end
      7:       return {1'b1, 31'($urandom)};
      8:       return 32'h7FFF_FFFF - $urandom_range(0, 200000);
      default: return $urandom >> $urandom_range(1, 31);
    endcase
  endfunction

  task automatic note_failure(
    input string what,
    input logic signed [ROOT_BITS-1:0] want,
    input logic signed [ROOT_BITS-1:0] got
  );
    failures++;
    if (failures <= REPORT_LIMIT)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  task automatic send_item(
    input logic signed [INPUT_BITS-1:0] v,
    input bit                           typed,
    input logic signed [ROOT_BITS-1:0]  root
  );
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    pending_roots.push_back(typed ? root : nearest_root(v));
    @(negedge clk);
  endtask

  // hold stall in random bursts
  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_roots.size() == 0) begin
        note_failure("unexpected transaction", '0, out_root);
      end else if (out_root !== pending_roots[0]) begin
        note_failure("root mismatch", pending_roots[0], out_root);
        void'(pending_roots.pop_front());
      end else begin
        void'(pending_roots.pop_front());
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= STALL_LIMIT) begin
      $display("tb_integer_sqrt_rounded_core: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i])
      send_item(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].root);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % SEGMENT_ITEMS == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_item(random_value(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb_integer_sqrt_rounded_core: PASS");
    end else begin
      $display("tb_integer_sqrt_rounded_core: FAIL");
    end
    $finish;
  end

endmodule
